// File: design/brake_detect_running_mean_core_macros.svh
// assertion helpers for the brake detect core
`ifndef BRAKE_DETECT_RUNNING_MEAN_CORE_MACROS_SVH
`define BRAKE_DETECT_RUNNING_MEAN_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define BDRM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define BDRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bdrm_pkg.sv
package bdrm_pkg;

    // field and datapath widths
    localparam int SMP_W  = 10;
    localparam int SUM_W  = 20;
    localparam int DEV_W  = SUM_W + 1;
    localparam int THR_W  = 10;
    localparam int HOLD_W = 16;
    localparam int AXES   = 3;
    localparam int AX_W   = 2;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // default tuning of the rescale step
    localparam int RESCALE_COUNT_DEF = 512;
    localparam int RESCALE_SHIFT_DEF = 3;

    // register reset values
    localparam logic [THR_W-1:0]  DECEL_THR_RST = 10'd20;
    localparam logic [THR_W-1:0]  LATERAL_RST   = 10'd30;
    localparam logic [THR_W-1:0]  HARD_THR_RST  = 10'd250;
    localparam logic [HOLD_W-1:0] HOLD_RST      = 16'd400;

    // axis slots, in processing order
    localparam logic [AX_W-1:0] AX_Z = 2'd0;
    localparam logic [AX_W-1:0] AX_X = 2'd1;
    localparam logic [AX_W-1:0] AX_Y = 2'd2;

    typedef enum logic [1:0] {
        REG_DECEL_THR,
        REG_LATERAL,
        REG_HARD_THR,
        REG_HOLD
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [THR_W-1:0]  decel_thr;
        logic [THR_W-1:0]  lateral;
        logic [THR_W-1:0]  hard_thr;
        logic [HOLD_W-1:0] hold;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic brake_lit;
        logic decel_detected;
    } t_result;

endpackage

// File: design/bdrm_div.sv
module bdrm_div import bdrm_pkg::*; #(
    parameter int DVS_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [SUM_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    w_trial;
    logic [DVS_W:0]    w_diff;
    logic              w_fits;
    logic              w_load;

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_fits  = (w_trial >= {1'b0, r_dvs});
    assign w_load  = i_start && !r_busy;

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (w_load) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_LAST;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - STEP_W'(1);
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// File: design/bdrm_ctrl.sv
module bdrm_ctrl import bdrm_pkg::*; #(
    parameter int RESCALE_COUNT = RESCALE_COUNT_DEF,
    parameter int RESCALE_SHIFT = RESCALE_SHIFT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_req_type,
    input  logic signed [SMP_W-1:0] i_accel_x,
    input  logic signed [SMP_W-1:0] i_accel_y,
    input  logic signed [SMP_W-1:0] i_accel_z,
    input  t_cfg                    i_cfg,
    input  logic                    i_slot_free,
    output logic                    o_push,
    output t_result                 o_result
);

    localparam int CNT_W = $clog2(RESCALE_COUNT + 2);
    localparam logic [CNT_W-1:0] RESCALE_AT = CNT_W'(RESCALE_COUNT);

    t_state                    r_state;
    t_state                    n_state;
    logic                      r_is_tick;
    logic signed [SMP_W-1:0]   r_smp [AXES];
    logic signed [SUM_W-1:0]   r_sum [AXES];
    logic signed [DEV_W-1:0]   r_dev [AXES];
    logic [CNT_W-1:0]          r_count;
    logic [AX_W-1:0]           r_axis;
    logic                      r_wait;
    logic [HOLD_W-1:0]         r_hold;
    logic                      r_light;
    t_result                   r_result;

    logic                      w_accept;
    logic                      w_div_start;
    t_div_stat                 w_div_stat;
    logic [SUM_W-1:0]          w_quo;
    logic [AX_W-1:0]           w_sel_axis;
    logic signed [SUM_W-1:0]   w_sel_sum;
    logic [SUM_W-1:0]          w_dividend;
    logic signed [DEV_W-1:0]   w_q_mag;
    logic signed [DEV_W-1:0]   w_q_s;
    logic signed [DEV_W-1:0]   w_smp_s;
    logic signed [DEV_W-1:0]   w_dev;
    logic signed [DEV_W-1:0]   w_dev_abs;
    logic signed [DEV_W-1:0]   w_decel_thr;
    logic signed [DEV_W-1:0]   w_lateral;
    logic signed [DEV_W-1:0]   w_hard_thr;
    logic                      w_detect;
    logic [HOLD_W-1:0]         w_hold_dec;
    logic signed [SMP_W-1:0]   w_in_smp [AXES];

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    assign w_in_smp[AX_Z] = i_accel_z;
    assign w_in_smp[AX_X] = i_accel_x;
    assign w_in_smp[AX_Y] = i_accel_y;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = i_req_type ? ST_EVAL : ST_DIV;
            end
            ST_DIV: begin
                if (w_div_stat.done && r_wait && r_axis == AX_Y) n_state = ST_EVAL;
            end
            ST_EVAL: n_state = ST_OUT;
            ST_OUT: begin
                if (i_slot_free) n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_push      = (r_state == ST_OUT) && i_slot_free;
        w_div_start = (r_state == ST_DIV) && !w_div_stat.busy &&
                      (!r_wait || (w_div_stat.done && r_axis != AX_Y));
    end

    // divider operands: current axis, or the next one when chaining
    assign w_sel_axis = (r_wait && r_axis != AX_Y) ? r_axis + AX_W'(1) : r_axis;
    assign w_sel_sum  = r_sum[w_sel_axis];
    assign w_dividend = w_sel_sum[SUM_W-1] ? SUM_W'(-w_sel_sum) : SUM_W'(w_sel_sum);

    bdrm_div #(
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_count),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    // deviation of the axis whose division just finished
    assign w_q_mag   = $signed({1'b0, w_quo});
    assign w_q_s     = r_sum[r_axis][SUM_W-1] ? -w_q_mag : w_q_mag;
    assign w_smp_s   = DEV_W'(r_smp[r_axis]);
    assign w_dev     = w_smp_s - w_q_s;
    assign w_dev_abs = (r_axis != AX_Z && w_dev < 0) ? -w_dev : w_dev;

    // detection test
    assign w_decel_thr = $signed({{(DEV_W-THR_W){1'b0}}, i_cfg.decel_thr});
    assign w_lateral   = $signed({{(DEV_W-THR_W){1'b0}}, i_cfg.lateral});
    assign w_hard_thr  = $signed({{(DEV_W-THR_W){1'b0}}, i_cfg.hard_thr});
    assign w_detect    = (r_dev[AX_Z] >= w_decel_thr && r_dev[AX_X] < w_lateral &&
                          r_dev[AX_Y] < w_lateral) || (r_dev[AX_Z] >= w_hard_thr);

    // hold countdown, stops at zero
    assign w_hold_dec = (r_hold != '0) ? r_hold - HOLD_W'(1) : r_hold;

    // running state and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_axis  <= AX_Z;
            r_wait  <= 1'b0;
            r_hold  <= '0;
            r_light <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_is_tick <= i_req_type;
                        r_axis    <= AX_Z;
                        r_wait    <= 1'b0;
                        if (!i_req_type) begin
                            r_count <= r_count + CNT_W'(1);
                            for (int i = 0; i < AXES; i++) begin
                                r_smp[i] <= w_in_smp[i];
                                r_sum[i] <= r_sum[i] + SUM_W'(w_in_smp[i]);
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_start) r_wait <= 1'b1;
                    if (w_div_stat.done && r_wait) begin
                        r_dev[r_axis] <= w_dev_abs;
                        if (r_axis != AX_Y) r_axis <= r_axis + AX_W'(1);
                    end
                end
                ST_EVAL: begin
                    if (r_is_tick) begin
                        r_hold <= w_hold_dec;
                        if (w_hold_dec == '0) r_light <= 1'b0;
                        r_result.brake_lit      <= (w_hold_dec == '0) ? 1'b0 : r_light;
                        r_result.decel_detected <= 1'b0;
                    end else begin
                        if (w_detect) begin
                            r_light <= 1'b1;
                            r_hold  <= i_cfg.hold;
                        end
                        r_result.brake_lit      <= w_detect || r_light;
                        r_result.decel_detected <= w_detect;
                        // keep the baseline adaptive
                        if (r_count > RESCALE_AT) begin
                            r_count <= r_count >> RESCALE_SHIFT;
                            for (int i = 0; i < AXES; i++) begin
                                r_sum[i] <= r_sum[i] >>> RESCALE_SHIFT;
                            end
                        end
                    end
                end
                ST_OUT: begin
                end
            endcase
        end
    end

    assign o_result = r_result;

endmodule

// File: design/brake_detect_running_mean_core.sv
// channel    | direction | transfer when                  | payload
// -----------+-----------+--------------------------------+------------------------------------
// input      | in        | i_in_valid & !o_in_stall       | i_req_type, i_accel_x/y/z
// result     | out       | o_out_valid & !i_out_stall     | o_brake_lit, o_decel_detected
// config     | in        | psel & penable & pwrite        | paddr, pwdata (prdata on reads)
//
// a sample's result needs three 20-step divisions of |sum| by the sample count, which run
// one after another in the shared serial divider
// a timer tick skips the divisions; one item is in work at a time, o_in_stall is high meanwhile
// a finished result sits in the output register, so the next item can enter while it waits
// synchronous active-low reset clears counts, sums, hold counter, light and output valid, and loads register defaults
`include "brake_detect_running_mean_core_macros.svh"

module brake_detect_running_mean_core import bdrm_pkg::*; #(
    parameter int RESCALE_COUNT = RESCALE_COUNT_DEF,
    parameter int RESCALE_SHIFT = RESCALE_SHIFT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_req_type,
    input  logic signed [SMP_W-1:0] i_accel_x,
    input  logic signed [SMP_W-1:0] i_accel_y,
    input  logic signed [SMP_W-1:0] i_accel_z,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_brake_lit,
    output logic                    o_decel_detected,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    t_cfg     r_cfg;
    logic     r_out_valid;
    t_result  r_out;

    t_reg_idx w_reg_idx;
    logic     w_cfg_wr;
    logic     w_slot_free;
    logic     w_push;
    t_result  w_result;

    // configuration registers
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decel_thr <= DECEL_THR_RST;
            r_cfg.lateral   <= LATERAL_RST;
            r_cfg.hard_thr  <= HARD_THR_RST;
            r_cfg.hold      <= HOLD_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_DECEL_THR: r_cfg.decel_thr <= pwdata[THR_W-1:0];
                REG_LATERAL:   r_cfg.lateral   <= pwdata[THR_W-1:0];
                REG_HARD_THR:  r_cfg.hard_thr  <= pwdata[THR_W-1:0];
                REG_HOLD:      r_cfg.hold      <= pwdata[HOLD_W-1:0];
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_reg_idx)
            REG_DECEL_THR: prdata = APB_DW'(r_cfg.decel_thr);
            REG_LATERAL:   prdata = APB_DW'(r_cfg.lateral);
            REG_HARD_THR:  prdata = APB_DW'(r_cfg.hard_thr);
            REG_HOLD:      prdata = APB_DW'(r_cfg.hold);
        endcase
    end

    // sequencer with running sums and shared divider
    bdrm_ctrl #(
        .RESCALE_COUNT (RESCALE_COUNT),
        .RESCALE_SHIFT (RESCALE_SHIFT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_cfg       (r_cfg),
        .i_slot_free (w_slot_free),
        .o_push      (w_push),
        .o_result    (w_result)
    );

    // output register
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_out <= w_result;
    end

    assign o_out_valid      = r_out_valid;
    assign o_brake_lit      = r_out.brake_lit;
    assign o_decel_detected = r_out.decel_detected;

    // checks
    `BDRM_ASSERT_SAME(a_push_needs_slot, w_push, !r_out_valid || !i_out_stall, "result pushed over a held result")
    `BDRM_ASSERT_SAME(a_detect_lights, o_out_valid && o_decel_detected, o_brake_lit, "detection without brake light")
    `BDRM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input taken while item in work")
    `BDRM_ASSERT_NEXT(a_out_drains, o_out_valid && !i_out_stall && !w_push, !o_out_valid, "result repeated after transfer")

endmodule

// File: dv/brake_detect_running_mean_core_test.sv
`timescale 1ns / 100ps

module brake_detect_running_mean_core_test;
    import bdrm_pkg::*;

    // request kinds on i_req_type
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam int HOLDOFF_CYCLES = 300;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 70;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct {
        logic                    kind;
        logic signed [SMP_W-1:0] x;
        logic signed [SMP_W-1:0] y;
        logic signed [SMP_W-1:0] z;
    } t_reading;

    // block ports, all inputs known from time zero
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_req_type = REQ_SAMPLE;
    logic signed [SMP_W-1:0] i_accel_x = '0;
    logic signed [SMP_W-1:0] i_accel_y = '0;
    logic signed [SMP_W-1:0] i_accel_z = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_brake_lit;
    logic                    o_decel_detected;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_AW-1:0]       paddr = '0;
    logic [APB_DW-1:0]       pwdata = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    // mirror of the detector's registers and running state
    t_cfg                     cfg = '{DECEL_THR_RST, LATERAL_RST, HARD_THR_RST, HOLD_RST};
    int                       mean_count = 0;
    logic signed [SUM_W-1:0]  acc_x = '0;
    logic signed [SUM_W-1:0]  acc_y = '0;
    logic signed [SUM_W-1:0]  acc_z = '0;
    logic [HOLD_W-1:0]        hold_left = '0;
    logic                     lit = 1'b0;
    int                       rescales = 0;

    t_result pending_lights[$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    int      hold_off_left = 0;
    int      quiet_cycles = 0;

    brake_detect_running_mean_core dut (.*);

    always #2 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch: %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // running-mean deceleration rule, one item at a time
    function automatic t_result apply_reading(input t_reading rd);
        t_result res;
        int      dev_x;
        int      dev_y;
        int      dev_z;
        res = '0;
        if (rd.kind == REQ_TICK) begin
            if (hold_left != 0) hold_left--;
            if (hold_left == 0) lit = 1'b0;
        end else begin
            mean_count++;
            acc_z = acc_z + rd.z;
            acc_x = acc_x + rd.x;
            acc_y = acc_y + rd.y;
            // truncating division, the mean includes this sample
            dev_z = int'(rd.z) - int'(acc_z) / mean_count;
            dev_x = int'(rd.x) - int'(acc_x) / mean_count;
            dev_y = int'(rd.y) - int'(acc_y) / mean_count;
            if (dev_x < 0) dev_x = -dev_x;
            if (dev_y < 0) dev_y = -dev_y;
            if ((dev_z >= int'(cfg.decel_thr) && dev_x < int'(cfg.lateral) &&
                 dev_y < int'(cfg.lateral)) || dev_z >= int'(cfg.hard_thr)) begin
                res.decel_detected = 1'b1;
                lit = 1'b1;
                hold_left = cfg.hold;
            end
            // shrink the window once the count passes the limit
            if (mean_count > RESCALE_COUNT_DEF) begin
                mean_count = mean_count >> RESCALE_SHIFT_DEF;
                acc_z = acc_z >>> RESCALE_SHIFT_DEF;
                acc_x = acc_x >>> RESCALE_SHIFT_DEF;
                acc_y = acc_y >>> RESCALE_SHIFT_DEF;
                rescales++;
            end
        end
        res.brake_lit = lit;
        return res;
    endfunction

    function automatic logic signed [SMP_W-1:0] to_axis(input int v);
        if (v > 511) return 10'sd511;
        if (v < -512) return -10'sd512;
        return v[SMP_W-1:0];
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // one register transfer: setup phase, access until pready, then idle
    task automatic apb_access(input logic wr, input t_reg_idx idx,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input t_reg_idx idx);
        logic [APB_DW-1:0] got;
        logic [APB_DW-1:0] want;
        apb_access(1'b0, idx, '0, got);
        case (idx)
            REG_DECEL_THR: want = APB_DW'(cfg.decel_thr);
            REG_LATERAL:   want = APB_DW'(cfg.lateral);
            REG_HARD_THR:  want = APB_DW'(cfg.hard_thr);
            default:       want = APB_DW'(cfg.hold);
        endcase
        if (got !== want) flag_mismatch($sformatf("readback of %s", idx.name()), got, want);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_DECEL_THR: cfg.decel_thr = value[THR_W-1:0];
            REG_LATERAL:   cfg.lateral = value[THR_W-1:0];
            REG_HARD_THR:  cfg.hard_thr = value[THR_W-1:0];
            default:       cfg.hold = value[HOLD_W-1:0];
        endcase
        check_reg(idx);
    endtask

    task automatic set_thresholds(input int soft_thr, input int side_lim, input int hard_thr,
                                  input int hold);
        write_reg(REG_DECEL_THR, soft_thr);
        write_reg(REG_LATERAL, side_lim);
        write_reg(REG_HARD_THR, hard_thr);
        write_reg(REG_HOLD, hold);
    endtask

    // random idle cycles on the input side
    task automatic pause_sender();
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // offer one item and hold it until the transfer
    task automatic send_reading(input t_reading rd);
        i_in_valid <= 1'b1;
        i_req_type <= rd.kind;
        i_accel_x <= rd.x;
        i_accel_y <= rd.y;
        i_accel_z <= rd.z;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        pending_lights.push_back(apply_reading(rd));
    endtask

    task automatic send_axes(input logic kind, input int x, input int y, input int z);
        t_reading rd;
        rd.kind = kind;
        rd.x = to_axis(x);
        rd.y = to_axis(y);
        rd.z = to_axis(z);
        send_reading(rd);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_lights.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // road-like stream: baseline plus noise, braking spikes, swerves, random outliers, ticks
    task automatic drive_readings(input int n_items, input int tick_pct,
                                  input bit until_rescaled);
        int       base_x;
        int       base_y;
        int       base_z;
        int       sent;
        int       pick;
        t_reading rd;
        base_x = jitter(300);
        base_y = jitter(300);
        base_z = jitter(300);
        sent = 0;
        while (sent < n_items || (until_rescaled && rescales == 0 && sent < 1200)) begin
            pick = $urandom_range(99);
            rd.kind = REQ_SAMPLE;
            if (pick < tick_pct) begin
                rd.kind = REQ_TICK;
                rd.x = SMP_W'($urandom);
                rd.y = SMP_W'($urandom);
                rd.z = SMP_W'($urandom);
            end else if (pick < tick_pct + 6) begin
                rd.x = SMP_W'($urandom);
                rd.y = SMP_W'($urandom);
                rd.z = SMP_W'($urandom);
            end else begin
                rd.x = to_axis(base_x + jitter(6));
                rd.y = to_axis(base_y + jitter(6));
                rd.z = to_axis(base_z + jitter(6));
                if ($urandom_range(99) < 15)
                    rd.z = to_axis(base_z + int'($urandom_range(320, 15)));
                if ($urandom_range(99) < 10)
                    rd.x = to_axis(base_x + jitter(80));
                if ($urandom_range(99) < 10)
                    rd.y = to_axis(base_y + jitter(80));
            end
            pause_sender();
            send_reading(rd);
            sent++;
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 4; i++) check_reg(t_reg_idx'(i));
        // tick while the hold counter is already empty, axis fields ignored
        send_axes(REQ_TICK, 511, -512, 511);
        send_axes(REQ_SAMPLE, 0, 0, 0);
        send_axes(REQ_SAMPLE, 511, 511, 511);
        send_axes(REQ_SAMPLE, -512, -512, -512);
        send_axes(REQ_SAMPLE, -512, 511, 0);
        send_axes(REQ_TICK, -512, 511, -512);
        send_axes(REQ_SAMPLE, 0, 0, 0);
        send_axes(REQ_SAMPLE, 2, -3, 60);
        send_axes(REQ_SAMPLE, 300, -300, 511);
        send_axes(REQ_SAMPLE, 511, -512, -512);
        send_axes(REQ_TICK, 0, 0, 0);
        wait_drained();
        // zero hold: lit by a detection, cleared by the next tick
        write_reg(REG_HOLD, 0);
        send_axes(REQ_SAMPLE, 0, 0, 511);
        send_axes(REQ_TICK, 0, 0, 0);
        send_axes(REQ_TICK, 0, 0, 0);
        wait_drained();
        // short hold counts down over ticks
        write_reg(REG_HOLD, 2);
        send_axes(REQ_SAMPLE, 0, 0, 511);
        send_axes(REQ_TICK, 0, 0, 0);
        send_axes(REQ_TICK, 0, 0, 0);
        send_axes(REQ_TICK, 0, 0, 0);
        wait_drained();
    endtask

    task automatic test_steady_flow();
        set_thresholds($urandom_range(60, 10), $urandom_range(80, 20),
                       $urandom_range(400, 150), $urandom_range(8, 1));
        send_idle_pct = 0;
        stall_pct = 0;
        drive_readings(130, 10, 1'b0);
        wait_drained();
    endtask

    task automatic test_sender_gaps();
        // every sample with a non-negative z deviation detects: zero thresholds, widest lateral band
        set_thresholds(0, 1023, 0, 1);
        send_idle_pct = 71;
        stall_pct = 0;
        drive_readings(130, 10, 1'b0);
        wait_drained();
    endtask

    task automatic test_receiver_stalls();
        // soft rule can never pass, longest hold
        set_thresholds(1023, 0, 1023, 65535);
        send_idle_pct = 0;
        stall_pct = 71;
        drive_readings(130, 10, 1'b0);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        set_thresholds(20, 30, 250, 3);
        send_idle_pct = 0;
        stall_pct = 0;
        @(posedge i_clk);
        hold_off_left = HOLDOFF_CYCLES;
        drive_readings(24, 15, 1'b0);
        wait_drained();
    endtask

    task automatic test_mixed_gaps();
        set_thresholds($urandom_range(1023), $urandom_range(1023),
                       $urandom_range(1023), $urandom_range(20, 1));
        send_idle_pct = 7;
        stall_pct = 7;
        // keep going until the running window has been rescaled at least once, up to 1200 items
        drive_readings(130, 10, 1'b1);
        wait_drained();
    endtask

    // result side: check each transfer
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_lights.size() == 0) begin
                flag_mismatch("result with nothing pending", 1, 0);
            end else begin
                want = pending_lights.pop_front();
                if (o_brake_lit !== want.brake_lit)
                    flag_mismatch("brake_lit", 32'(o_brake_lit), 32'(want.brake_lit));
                if (o_decel_detected !== want.decel_detected)
                    flag_mismatch("decel_detected", 32'(o_decel_detected),
                                  32'(want.decel_detected));
            end
        end
    end

    // receiver stall pattern, with a counted hold-off stretch
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_stall <= 1'b1;
            hold_off_left--;
        end else begin
            i_out_stall <= (int'($urandom_range(99)) < stall_pct);
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("brake_detect_running_mean_core_test: errors");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_steady_flow();
        test_sender_gaps();
        test_receiver_stalls();
        test_output_backpressure();
        test_mixed_gaps();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_lights.size() != 0)
            flag_mismatch("results never produced", pending_lights.size(), 0);
        if (mismatches == 0) begin
            $display("brake_detect_running_mean_core_test: clean");
        end else begin
            $display("brake_detect_running_mean_core_test: errors");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/bdrm_pkg.sv
design/bdrm_div.sv
design/bdrm_ctrl.sv
design/brake_detect_running_mean_core.sv
dv/brake_detect_running_mean_core_test.sv
